[hdl/jtma_pkg.sv]
// ----------------------------------------------------------------------------
// jtma_pkg: shared types, constants and arithmetic for the joystick angle filter
// Scaling of millivolts to tenths of a degree and of tenths to whole degrees.
// ----------------------------------------------------------------------------
package jtma_pkg;

    // Field types
    typedef logic        [11:0] t_mv;      // raw sample voltage, mV
    typedef logic signed [8:0]  t_tenths;  // scaled sample or average, -200..200
    typedef logic signed [5:0]  t_angle;   // whole degrees, -20..20

    // Per-axis accumulator control
    typedef struct packed {
        logic en;      // take the sample in the input register
        logic first;   // sample opens a new window
    } t_axis_ctl;

    // Window defaults
    localparam int WINDOW_SIZE_DEF = 10;
    localparam int FULL_SCALE      = 200;
    localparam int SUM_W_DEF       = $clog2(WINDOW_SIZE_DEF * FULL_SCALE + 1) + 1;

    // Voltage clamp and scaling: (v - 300) * 400 / 2400 = (v - 300) / 6
    localparam int MV_LOW      = 300;
    localparam int MV_HIGH     = 2700;
    localparam int SCALE_RECIP = 10923;    // ceil(2^16 / 6)
    localparam int SCALE_SHIFT = 16;

    // Trimmed mean divide by reciprocal
    localparam int DIV_SHIFT   = 18;

    // Deadzone and divide by ten
    localparam int DEADZONE    = 10;
    localparam int DIV10_RECIP = 205;      // ceil(2^11 / 10)
    localparam int DIV10_SHIFT = 11;

    // Clamp a voltage and scale it to tenths of a degree
    function automatic t_tenths scale_mv(input t_mv mv);
        logic        [11:0] v;
        logic        [11:0] d;
        logic        [25:0] p;
        logic        [8:0]  q;
        logic signed [9:0]  t;
        v = mv;
        if (mv < 12'(MV_LOW)) begin
            v = 12'(MV_LOW);
        end else if (mv > 12'(MV_HIGH)) begin
            v = 12'(MV_HIGH);
        end
        d = v - 12'(MV_LOW);
        p = 26'(d) * 26'(SCALE_RECIP);
        q = p[SCALE_SHIFT +: 9];
        t = $signed({1'b0, q}) - $signed(10'(FULL_SCALE));
        return t_tenths'(t[8:0]);
    endfunction

    // Apply the deadzone, then truncate tenths to whole degrees
    function automatic t_angle angle_of(input t_tenths avg);
        logic [8:0]  n;
        logic [7:0]  mag;
        logic [18:0] p;
        logic [4:0]  q;
        logic [5:0]  r;
        n   = avg[8] ? 9'(-avg) : 9'(avg);
        mag = n[7:0];
        p   = 19'(mag) * 19'(DIV10_RECIP);
        q   = p[DIV10_SHIFT +: 5];
        r   = avg[8] ? 6'(-{1'b0, q}) : {1'b0, q};
        if ((avg > -$signed(9'(DEADZONE))) && (avg < $signed(9'(DEADZONE)))) begin
            r = '0;
        end
        return t_angle'(r);
    endfunction

endpackage

[hdl/jtma_if.sv]
// ----------------------------------------------------------------------------
// jtma_if: valid/ready channels of the joystick angle filter
// Sample channel (X and Y millivolts) and result channel (angles, changed).
// ----------------------------------------------------------------------------
interface jtma_in_if
    import jtma_pkg::*;
();
    logic valid;
    logic ready;
    t_mv  x_millivolts;
    t_mv  y_millivolts;

    modport source (output valid, output x_millivolts, output y_millivolts, input ready);
    modport sink   (input valid, input x_millivolts, input y_millivolts, output ready);
endinterface

interface jtma_out_if
    import jtma_pkg::*;
();
    logic   valid;
    logic   ready;
    t_angle x_angle;
    t_angle y_angle;
    logic   changed;

    modport source (output valid, output x_angle, output y_angle, output changed,
                    input ready);
    modport sink   (input valid, input x_angle, input y_angle, input changed,
                    output ready);
endinterface

[hdl/jtma_axis.sv]
// ----------------------------------------------------------------------------
// jtma_axis: running sum, minimum and maximum of one axis
// Gives the trimmed sum (sum - min - max) including the current sample.
// ----------------------------------------------------------------------------
module jtma_axis
    import jtma_pkg::*;
#(
    parameter int SUM_W = SUM_W_DEF
) (
    input  logic                    i_clk,
    input  t_axis_ctl               i_ctl,
    input  t_tenths                 i_sample,
    output logic signed [SUM_W:0]   o_trim
);

    logic signed [SUM_W-1:0] r_sum, n_sum;
    t_tenths                 r_min, n_min;
    t_tenths                 r_max, n_max;
    logic signed [SUM_W-1:0] sample_ext;

    assign sample_ext = {{(SUM_W - 9){i_sample[8]}}, i_sample};

    always_comb begin
        if (i_ctl.first) begin
            n_sum = sample_ext;
            n_min = i_sample;
            n_max = i_sample;
        end else begin
            n_sum = r_sum + sample_ext;
            n_min = (i_sample < r_min) ? i_sample : r_min;
            n_max = (i_sample > r_max) ? i_sample : r_max;
        end
    end

    // Window state is reloaded by the first sample, so it needs no reset
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_sum <= n_sum;
            r_min <= n_min;
            r_max <= n_max;
        end
    end

    assign o_trim = (SUM_W + 1)'(n_sum) - (SUM_W + 1)'(n_min) - (SUM_W + 1)'(n_max);

endmodule

[hdl/joystick_trimmed_mean_angle.sv]
// ----------------------------------------------------------------------------
// joystick_trimmed_mean_angle: windowed trimmed-mean joystick angle filter
// Clamps and scales X/Y voltages, averages each window without its extremes,
// applies a deadzone and flags a change against the last result.
// ----------------------------------------------------------------------------
// Usage: one sample pair is taken on every transfer at i_in, one per clock
// at full rate. Every WINDOW_SIZE samples the block emits one result at o_out;
// other samples give none. After the transfer of the window's last sample,
// the result passes through the input register, the accumulator
// that forms the trimmed sum, the reciprocal multiply that divides it by
// WINDOW_SIZE - 2, and the result register that applies the deadzone and
// the change flag. Each stage holds its item while the next is full, so
// samples keep flowing while a result waits to be taken; input stalls only
// once a window's result would have to enter a full stage. Voltages outside
// 300..2700 mV are clamped. Angles are whole degrees in -20..20, truncated
// toward zero; changed is set when either angle differs from the previous
// result (both zero after reset).
// ----------------------------------------------------------------------------
module joystick_trimmed_mean_angle
    import jtma_pkg::*;
#(
    parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    jtma_in_if.sink   i_in,
    jtma_out_if.source o_out
);

    // Derived sizes
    localparam int CNT_W     = $clog2(WINDOW_SIZE);
    localparam int SUM_W     = $clog2(WINDOW_SIZE * FULL_SCALE + 1) + 1;
    localparam int MAG_W     = SUM_W - 1;
    localparam int DIVISOR   = WINDOW_SIZE - 2;
    localparam int RECIP     = ((1 << DIV_SHIFT) + DIVISOR - 1) / DIVISOR;
    localparam int RECIP_W   = $clog2(RECIP + 1);
    localparam int PROD_W    = MAG_W + RECIP_W;

    // Stage 0: input register, samples already scaled to tenths
    logic            r_in_v;
    t_tenths         r_in_x, r_in_y;
    logic [CNT_W-1:0] r_cnt;

    // Stage 1: trimmed sums as sign and magnitude
    logic             r_t_v;
    logic             r_t_xs, r_t_ys;
    logic [MAG_W-1:0] r_t_xm, r_t_ym;

    // Stage 2: averages in tenths
    logic            r_a_v;
    t_tenths         r_a_x, r_a_y;

    // Stage 3: result register and last emitted angles
    logic            r_o_v;
    t_angle          r_o_x, r_o_y;
    logic            r_o_ch;
    t_angle          r_last_x, r_last_y;

    logic            cnt_first, cnt_last;
    logic            adv0, rdy1, rdy2, rdy3;
    t_axis_ctl       axis_ctl;
    logic signed [SUM_W:0] trim_x, trim_y;
    logic [SUM_W:0]  neg_x, neg_y;
    logic [PROD_W-1:0] prod_x, prod_y;
    logic [7:0]      quot_x, quot_y;
    t_angle          ang_x, ang_y;

    // Handshake chain: each stage takes a new item when empty or when
    // its item moves on in the same cycle
    assign cnt_first = (r_cnt == '0);
    assign cnt_last  = (r_cnt == CNT_W'(WINDOW_SIZE - 1));
    assign rdy3      = !r_o_v || o_out.ready;
    assign rdy2      = !r_a_v || rdy3;
    assign rdy1      = !r_t_v || rdy2;
    // A sample that closes the window needs room in stage 1; others never stall
    assign adv0      = r_in_v && (!cnt_last || rdy1);
    assign i_in.ready = !r_in_v || adv0;

    // Stage 0: scale on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (i_in.ready) begin
            r_in_v <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_x <= scale_mv(i_in.x_millivolts);
            r_in_y <= scale_mv(i_in.y_millivolts);
        end
    end

    // Window position: advance per sample, wrap after the last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (adv0) begin
            r_cnt <= cnt_last ? '0 : r_cnt + 1'b1;
        end
    end

    assign axis_ctl.en    = adv0;
    assign axis_ctl.first = cnt_first;

    jtma_axis #(
        .SUM_W    (SUM_W)
    ) u_axis_x (
        .i_clk    (i_clk),
        .i_ctl    (axis_ctl),
        .i_sample (r_in_x),
        .o_trim   (trim_x)
    );

    jtma_axis #(
        .SUM_W    (SUM_W)
    ) u_axis_y (
        .i_clk    (i_clk),
        .i_ctl    (axis_ctl),
        .i_sample (r_in_y),
        .o_trim   (trim_y)
    );

    // Stage 1: hold trimmed sums of the completed window
    assign neg_x = (SUM_W + 1)'(-trim_x);
    assign neg_y = (SUM_W + 1)'(-trim_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_v <= 1'b0;
        end else if (rdy1) begin
            r_t_v <= adv0 && cnt_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && adv0 && cnt_last) begin
            r_t_xs <= trim_x[SUM_W];
            r_t_ys <= trim_y[SUM_W];
            r_t_xm <= trim_x[SUM_W] ? neg_x[MAG_W-1:0] : trim_x[MAG_W-1:0];
            r_t_ym <= trim_y[SUM_W] ? neg_y[MAG_W-1:0] : trim_y[MAG_W-1:0];
        end
    end

    // Stage 2: divide magnitude by WINDOW_SIZE - 2, truncating toward zero
    assign prod_x = PROD_W'(r_t_xm) * PROD_W'(RECIP);
    assign prod_y = PROD_W'(r_t_ym) * PROD_W'(RECIP);
    assign quot_x = prod_x[DIV_SHIFT +: 8];
    assign quot_y = prod_y[DIV_SHIFT +: 8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (rdy2) begin
            r_a_v <= r_t_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && r_t_v) begin
            r_a_x <= r_t_xs ? t_tenths'(-{1'b0, quot_x}) : t_tenths'({1'b0, quot_x});
            r_a_y <= r_t_ys ? t_tenths'(-{1'b0, quot_y}) : t_tenths'({1'b0, quot_y});
        end
    end

    // Stage 3: deadzone, whole degrees, change against the last result
    assign ang_x = angle_of(r_a_x);
    assign ang_y = angle_of(r_a_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v    <= 1'b0;
            r_last_x <= '0;
            r_last_y <= '0;
        end else if (rdy3) begin
            r_o_v <= r_a_v;
            if (r_a_v) begin
                // Unchanged angles leave last as it was, so always copy
                r_last_x <= ang_x;
                r_last_y <= ang_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3 && r_a_v) begin
            r_o_x  <= ang_x;
            r_o_y  <= ang_y;
            r_o_ch <= (ang_x != r_last_x) || (ang_y != r_last_y);
        end
    end

    assign o_out.valid   = r_o_v;
    assign o_out.x_angle = r_o_x;
    assign o_out.y_angle = r_o_y;
    assign o_out.changed = r_o_ch;

    // Window position never passes the last sample
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_cnt} < (CNT_W + 1)'(WINDOW_SIZE))
        else $error("window position out of range");

    // A waiting result always matches the recorded last angles
    a_last_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_v |-> (r_o_x == r_last_x) && (r_o_y == r_last_y))
        else $error("last angles disagree with held result");

    // Averages stay within full scale
    a_avg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_v |-> (r_a_x >= -9'sd200) && (r_a_x <= 9'sd200)
                  && (r_a_y >= -9'sd200) && (r_a_y <= 9'sd200))
        else $error("average outside full scale");

    // Emitted angles stay within twenty degrees
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_v |-> (r_o_x >= -6'sd20) && (r_o_x <= 6'sd20)
                  && (r_o_y >= -6'sd20) && (r_o_y <= 6'sd20))
        else $error("angle outside range");

    // A result held back by the sink stays unchanged
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_v && !o_out.ready) |=> r_o_v && $stable(r_o_x) && $stable(r_o_y)
                                   && $stable(r_o_ch))
        else $error("held result changed");

endmodule
